// ===== rtl/lst_pkg.sv =====
// Shared constants for the latency statistics tracker.
// Register map, field widths and default window depth; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lst_pkg;

   // Width of every timer reading and statistic word.
   localparam int DATA_W = 32;

   // Default number of samples in the moving-average window.
   localparam int DEFAULT_WINDOW_DEPTH = 16;

   // Configuration port geometry: one 32-bit register at byte address 0.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from the word address bit.
   typedef enum logic {
      REG_TIMER_MAX = 1'b0
   } csr_reg_type;

   // Reset value of the timer wrap point.
   localparam logic [DATA_W-1:0] TIMER_MAX_RESET = {DATA_W{1'b1}};

endpackage : lst_pkg

`default_nettype wire

// ===== rtl/lst_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read with read-before-write behavior; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array; a read of the entry being written returns the old value.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : lst_ram

`default_nettype wire

// ===== rtl/latency_statistics_tracker.sv =====
// Top level of the latency statistics tracker.
// Depends on lst_pkg for constants and on lst_ram for the sample window.
`timescale 1ns / 1ps
`default_nettype none

// The tracker takes one word per cycle, each a start and stop timer reading,
// and returns one result word per input word: the wrap-corrected interval,
// the moving average over the last WINDOW_DEPTH intervals, and the minimum
// and maximum since reset. It is a two-stage pipeline: the first stage forms
// the interval and writes it into the window RAM while reading the sample it
// replaces; the second stage updates the running sum, minimum and maximum and
// holds the result in the output register. An accepted word passes through the
// stage-one registers and then the output register before its result is
// presented. A new word can be accepted every cycle while the
// result side keeps up; a stalled result holds the pipeline.
// The window reads as all zero after reset without any clearing pass, so
// words are accepted from the first cycle out of reset. The average is the
// running sum shifted right by floor(log2(WINDOW_DEPTH)), saturated to 32
// bits. The timer wrap point register (reset all ones) should be written
// only while the block is idle.

module latency_statistics_tracker #(
   parameter int WINDOW_DEPTH = lst_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Measurement input
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [lst_pkg::DATA_W-1:0]       req_start_time,
   input  wire logic [lst_pkg::DATA_W-1:0]       req_stop_time,
   // Statistics output
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [lst_pkg::DATA_W-1:0]       rsp_elapsed,
   output logic      [lst_pkg::DATA_W-1:0]       rsp_average,
   output logic      [lst_pkg::DATA_W-1:0]       rsp_minimum,
   output logic      [lst_pkg::DATA_W-1:0]       rsp_maximum,
   // Configuration port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [lst_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [lst_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [lst_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   localparam int DW     = lst_pkg::DATA_W;
   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = DW + $clog2(WINDOW_DEPTH);
   localparam int SHIFT  = $clog2(WINDOW_DEPTH + 1) - 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
   localparam logic [SUM_W-1:0]  AVG_LIMIT = SUM_W'({DW{1'b1}});

   // Configuration register
   logic [DW-1:0]            timer_max_ff;
   logic [DW-1:0]            timer_max_in;
   logic                     csr_write;
   lst_pkg::csr_reg_type     csr_reg;

   // Pipeline control
   logic                     accept;
   logic                     s2_load;
   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   // Ring position and window fill state
   logic [SLOT_W-1:0]        slot_ff;
   logic [SLOT_W-1:0]        slot_in;
   logic                     wrapped_ff;
   logic                     wrapped_in;

   // Stage one payload
   logic [DW-1:0]            elapsed;
   logic [DW-1:0]            s1_elapsed_ff;
   logic                     s1_old_valid_ff;
   logic [DW-1:0]            ram_rd_data;

   // Statistics state
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W-1:0]         sum_in;
   logic [DW-1:0]            min_ff;
   logic [DW-1:0]            min_in;
   logic [DW-1:0]            max_ff;
   logic [DW-1:0]            max_in;
   logic                     have_sample_ff;
   logic [DW-1:0]            old_sample;
   logic [SUM_W-1:0]         sum_shifted;

   // Output register
   logic [DW-1:0]            rsp_elapsed_ff;
   logic [DW-1:0]            rsp_average_ff;
   logic [DW-1:0]            average_in;

   // Configuration decode; the word address bit selects the register.
   assign csr_pready = 1'b1;
   assign csr_reg    = lst_pkg::csr_reg_type'(csr_paddr[2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      timer_max_in = timer_max_ff;
      csr_prdata   = '0;
      unique case (csr_reg)
         lst_pkg::REG_TIMER_MAX: begin
            csr_prdata = timer_max_ff;
            if (csr_write) begin
               timer_max_in = csr_pwdata;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_max_ff <= lst_pkg::TIMER_MAX_RESET;
      end else begin
         timer_max_ff <= timer_max_in;
      end
   end

   // Handshake: stage one moves on when the output register is free or drains.
   assign s2_load      = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall    = s1_valid_ff & ~s2_load;
   assign accept       = req_valid & ~req_stall;
   assign s1_valid_in  = accept | (s1_valid_ff & ~s2_load);
   assign rsp_valid_in = s2_load | (rsp_valid_ff & rsp_stall);

   // Wrap-corrected interval length, modulo 2^32.
   always_comb begin
      if (req_stop_time >= req_start_time) begin
         elapsed = req_stop_time - req_start_time;
      end else begin
         elapsed = timer_max_ff - req_start_time + req_stop_time;
      end
   end

   // Ring position advances per accepted word; the window counts as filled
   // once the position has wrapped.
   always_comb begin
      slot_in    = slot_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (slot_ff == LAST_SLOT) begin
            slot_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   // Window memory: the new interval replaces the oldest, whose value is read
   // out in the same access.
   lst_ram #(
      .WIDTH (DW),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (elapsed),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // Stage one registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         slot_ff     <= '0;
         wrapped_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         slot_ff     <= slot_in;
         wrapped_ff  <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_elapsed_ff   <= elapsed;
         s1_old_valid_ff <= wrapped_ff;
      end
   end

   // Running sum, average and extremes for the word in stage one.
   always_comb begin
      old_sample  = s1_old_valid_ff ? ram_rd_data : '0;
      sum_in      = sum_ff - SUM_W'(old_sample) + SUM_W'(s1_elapsed_ff);
      sum_shifted = sum_in >> SHIFT;
      if (sum_shifted > AVG_LIMIT) begin
         average_in = {DW{1'b1}};
      end else begin
         average_in = sum_shifted[DW-1:0];
      end
      if (!have_sample_ff) begin
         min_in = s1_elapsed_ff;
         max_in = s1_elapsed_ff;
      end else begin
         min_in = (s1_elapsed_ff < min_ff) ? s1_elapsed_ff : min_ff;
         max_in = (s1_elapsed_ff > max_ff) ? s1_elapsed_ff : max_ff;
      end
   end

   // Statistics state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         have_sample_ff <= 1'b0;
         sum_ff         <= '0;
         min_ff         <= '0;
         max_ff         <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s2_load) begin
            have_sample_ff <= 1'b1;
            sum_ff         <= sum_in;
            min_ff         <= min_in;
            max_ff         <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_elapsed_ff <= s1_elapsed_ff;
         rsp_average_ff <= average_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_elapsed = rsp_elapsed_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_minimum = min_ff;
   assign rsp_maximum = max_ff;

endmodule : latency_statistics_tracker

`default_nettype wire

// ===== tb/sv/tb_latency_statistics_tracker.sv =====
// Self-checking testbench for the latency statistics tracker.
// Needs lst_pkg and latency_statistics_tracker; a predictor models the window and statistics.
`timescale 1ns / 1ps

module tb_latency_statistics_tracker;

   localparam int DATA_W = lst_pkg::DATA_W;
   localparam int CSR_ADDR_W = lst_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = lst_pkg::CSR_DATA_W;
   localparam int WINDOW_DEPTH = lst_pkg::DEFAULT_WINDOW_DEPTH;
   // floor(log2(depth)), valid for any depth.
   localparam int AVG_SHIFT = $clog2(WINDOW_DEPTH + 1) - 1;
   localparam int SPARE_REG_INDEX = 1;
   localparam int PHASE_COUNT = 6;
   localparam int RANDOM_PER_PHASE = 290;
   localparam int DRAIN_CYCLES = 8;
   localparam int RUN_LIMIT_NS = 2_000_000;

   typedef struct packed {
      logic [DATA_W-1:0] elapsed;
      logic [DATA_W-1:0] average;
      logic [DATA_W-1:0] minimum;
      logic [DATA_W-1:0] maximum;
   } stats_type;

   typedef struct packed {
      logic [DATA_W-1:0] start_time;
      logic [DATA_W-1:0] stop_time;
      logic              typed;
      stats_type         stats;
   } probe_row_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BLOCKS
   } stall_pattern_type;

   localparam stats_type NO_STATS = '0;
   localparam int DIRECTED_COUNT = 20;

   // Directed words; the first rows after reset carry hand-computed results.
   localparam probe_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{32'h0000_0010, 32'h0000_0030, 1'b1,
        '{32'h0000_0020, 32'h0000_0002, 32'h0000_0020, 32'h0000_0020}},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
        '{32'hFFFF_FFFF, 32'h1000_0001, 32'h0000_0020, 32'hFFFF_FFFF}},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 32'h1000_0001, 32'h0000_0000, 32'hFFFF_FFFF}},
      '{32'h0000_0001, 32'h0000_0000, 1'b1,
        '{32'hFFFF_FFFE, 32'h2000_0001, 32'h0000_0000, 32'hFFFF_FFFF}},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
        '{32'hFFFF_FFFE, 32'h3000_0001, 32'h0000_0000, 32'hFFFF_FFFF}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_STATS},
      '{32'h0000_0000, 32'h0000_0000, 1'b0, NO_STATS},
      '{32'h0000_0000, 32'h0000_0001, 1'b0, NO_STATS},
      '{32'h0000_0001, 32'h0000_0000, 1'b0, NO_STATS},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, NO_STATS},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, NO_STATS},
      '{32'h1234_5678, 32'h1234_5678, 1'b0, NO_STATS},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, NO_STATS},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_STATS},
      '{32'hFFFF_FFFE, 32'h0000_0001, 1'b0, NO_STATS},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, NO_STATS},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_STATS},
      '{32'hDEAD_BEEF, 32'h0000_BEEF, 1'b0, NO_STATS},
      '{32'h0000_0100, 32'h0000_0200, 1'b0, NO_STATS},
      '{32'h0000_FFFF, 32'hFFFF_0000, 1'b0, NO_STATS}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DATA_W-1:0]     req_start_time = '0;
   logic [DATA_W-1:0]     req_stop_time = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DATA_W-1:0]     rsp_elapsed;
   logic [DATA_W-1:0]     rsp_average;
   logic [DATA_W-1:0]     rsp_minimum;
   logic [DATA_W-1:0]     rsp_maximum;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state: wrap point, sample window, running sum and extremes.
   logic [DATA_W-1:0] wrap_point;
   logic [DATA_W-1:0] window_sample [WINDOW_DEPTH];
   int unsigned       window_slot;
   logic [63:0]       window_sum;
   logic [DATA_W-1:0] low_mark;
   logic [DATA_W-1:0] high_mark;
   bit                seen_sample;

   stats_type   stats_due_q [$];
   int unsigned fail_count = 0;
   int unsigned burst_left = 0;
   bit          sender_steady = 1'b0;

   latency_statistics_tracker #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_time (req_start_time),
      .req_stop_time  (req_stop_time),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_elapsed    (rsp_elapsed),
      .rsp_average    (rsp_average),
      .rsp_minimum    (rsp_minimum),
      .rsp_maximum    (rsp_maximum),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // Takes one interval into the window and returns the statistics after it.
   function automatic stats_type track_interval(logic [DATA_W-1:0] start_time,
                                                logic [DATA_W-1:0] stop_time);
      stats_type   result;
      logic [63:0] mean;
      if (stop_time >= start_time)
         result.elapsed = stop_time - start_time;
      else
         result.elapsed = wrap_point - start_time + stop_time;
      window_sum = window_sum - 64'(window_sample[window_slot]) + 64'(result.elapsed);
      window_sample[window_slot] = result.elapsed;
      window_slot = (window_slot + 1) % WINDOW_DEPTH;
      mean = window_sum >> AVG_SHIFT;
      result.average = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[DATA_W-1:0];
      if (!seen_sample) begin
         low_mark = result.elapsed;
         high_mark = result.elapsed;
         seen_sample = 1'b1;
      end else begin
         if (result.elapsed < low_mark) low_mark = result.elapsed;
         if (result.elapsed > high_mark) high_mark = result.elapsed;
      end
      result.minimum = low_mark;
      result.maximum = high_mark;
      return result;
   endfunction

   // A timer reading at one of the interesting boundaries.
   function automatic logic [DATA_W-1:0] boundary_reading();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return wrap_point;
         3: return wrap_point + 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Sends one measurement word; the sender runs in bursts with random gaps, none when steady.
   task automatic send_word(logic [DATA_W-1:0] start_time, logic [DATA_W-1:0] stop_time,
                            bit typed, stats_type typed_stats);
      int unsigned gap;
      stats_type   predicted;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_steady ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_start_time <= start_time;
      req_stop_time <= stop_time;
      do @(posedge clock); while (req_stall);
      predicted = track_interval(start_time, stop_time);
      stats_due_q.push_back(typed ? typed_stats : predicted);
   endtask

   // One APB transfer: setup cycle, then access cycle until pready.
   task automatic csr_access(bit write, int unsigned index, logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= CSR_ADDR_W'(4 * index);
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (write && index == int'(lst_pkg::REG_TIMER_MAX)) wrap_point = wdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Receiver stall pattern, switching to a random style after each run of random length.
   stall_pattern_type stall_pattern = STALL_NONE;
   int unsigned       stall_run = 0;
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_pattern = stall_pattern_type'($urandom_range(0, 3));
         stall_run = $urandom_range(8, 64);
      end
      stall_run--;
      case (stall_pattern)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
         default:     rsp_stall <= ((stall_run % 8) < 5);
      endcase
   end

   // Each accepted result word is compared with the oldest expectation.
   always @(posedge clock) begin : result_check
      stats_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stats_due_q.size() == 0) begin
            $error("result word with no expectation waiting: elapsed %h", rsp_elapsed);
            fail_count++;
         end else begin
            want = stats_due_q.pop_front();
            check_field("elapsed", want.elapsed, rsp_elapsed);
            check_field("average", want.average, rsp_average);
            check_field("minimum", want.minimum, rsp_minimum);
            check_field("maximum", want.maximum, rsp_maximum);
         end
      end
   end

   initial begin : stimulus
      logic [DATA_W-1:0]     start_time;
      logic [DATA_W-1:0]     stop_time;
      logic [CSR_DATA_W-1:0] setting;
      logic [CSR_DATA_W-1:0] readback;

      // Predictor starts from the reset state.
      wrap_point = lst_pkg::TIMER_MAX_RESET;
      foreach (window_sample[i]) window_sample[i] = '0;
      window_slot = 0;
      window_sum = '0;
      low_mark = '0;
      high_mark = '0;
      seen_sample = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // New wrap point only once the block has drained.
         if (phase != 0) begin
            while (stats_due_q.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
            case (phase)
               1: setting = 32'h0000_0001;
               2: setting = $urandom;
               3: setting = '0;
               4: setting = 32'h0000_FFFF;
               default: setting = '1;
            endcase
            csr_access(1'b1, int'(lst_pkg::REG_TIMER_MAX), setting, readback);
            // A write to an unmapped register must leave the wrap point alone.
            if (phase == 4) csr_access(1'b1, SPARE_REG_INDEX, $urandom, readback);
            csr_access(1'b0, int'(lst_pkg::REG_TIMER_MAX), '0, readback);
            if (readback !== wrap_point) begin
               $error("timer_max readback: expected %h, actual %h", wrap_point, readback);
               fail_count++;
            end
         end
         sender_steady = (phase == 2 || phase == 5);

         if (phase == 0) begin
            for (int row = 0; row < DIRECTED_COUNT; row++)
               send_word(DIRECTED_ROWS[row].start_time, DIRECTED_ROWS[row].stop_time,
                         DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].stats);
         end

         // Random words: mostly realistic intervals, some wrapped, some arbitrary.
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  start_time = $urandom;
                  stop_time = start_time + $urandom_range(0, 5000);
               end
               4, 5: begin
                  start_time = wrap_point - $urandom_range(0, 1000);
                  stop_time = $urandom_range(0, 1000);
               end
               6: begin
                  start_time = $urandom;
                  stop_time = $urandom;
               end
               7: begin
                  start_time = $urandom;
                  stop_time = start_time;
               end
               8: begin
                  start_time = boundary_reading();
                  stop_time = boundary_reading();
               end
               default: begin
                  start_time = $urandom_range(0, 255);
                  stop_time = $urandom | 32'h8000_0000;
               end
            endcase
            send_word(start_time, stop_time, 1'b0, NO_STATS);
         end
         @(negedge clock);
         req_valid <= 1'b0;
      end

      while (stats_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
